FILE: hw/rtl/tss_pkg.sv
// tss_pkg: shared types, constants and helpers for the text stream statistics block.
// No dependencies.
package tss_pkg;

    localparam int DEF_MAX_PATTERN = 9;

    localparam int CNT_W = 32;
    localparam int CFG_W = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
    } t_item;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
        sat_inc = (en && (v != {CNT_W{1'b1}})) ? v + 1'b1 : v;
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        is_sep = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NEWLINE);
    endfunction

endpackage

FILE: hw/rtl/tss_window.sv
// tss_window: recent-byte window, fill and match-distance tracking, parallel pattern compare.
// Depends on tss_pkg.
module tss_window #(
    parameter int MAX_PATTERN = tss_pkg::DEF_MAX_PATTERN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  tss_pkg::t_item i_item,
    input  logic [63:0]   i_pat_low,
    input  logic [7:0]    i_pat_high,
    input  logic [3:0]    i_pat_len,
    output logic          o_hit
);
    import tss_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]             r_win [MAX_PATTERN];
    logic [7:0]             n_win [MAX_PATTERN];
    logic [7:0]             pat   [MAX_PATTERN];
    logic [LW-1:0]          r_fill, n_fill, r_since, n_since;
    logic [LW-1:0]          fill_inc, since_inc, len;
    logic [MAX_PATTERN-1:0] pos_ok;

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_pat
        if (g < 8) begin : g_low
            assign pat[g] = i_pat_low[8*g +: 8];
        end else if (g == 8) begin : g_high
            assign pat[g] = i_pat_high;
        end else begin : g_zero
            assign pat[g] = 8'h00;
        end
    end

    always_comb begin
        n_win[0] = i_item.text_byte;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            n_win[i] = r_win[i-1];
        end

        fill_inc  = (r_fill == LW'(MAX_PATTERN)) ? r_fill : r_fill + 1'b1;
        since_inc = (r_since == LW'(MAX_PATTERN)) ? r_since : r_since + 1'b1;

        if (32'(i_pat_len) > 32'(MAX_PATTERN)) begin
            len = LW'(MAX_PATTERN);
        end else begin
            len = LW'(i_pat_len);
        end

        // newest byte sits at window slot 0 and pairs with the last pattern byte
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pos_ok[i] = (LW'(i) >= len) || (n_win[i] == pat[IW'(int'(len) - 1 - i)]);
        end

        o_hit = (len != '0) && (fill_inc >= len) && (since_inc >= len) && (&pos_ok);

        n_fill  = fill_inc;
        n_since = o_hit ? '0 : since_inc;
        if (i_item.is_last) begin
            n_fill  = '0;
            n_since = LW'(MAX_PATTERN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_since <= LW'(MAX_PATTERN);
        end else if (i_adv) begin
            r_fill  <= n_fill;
            r_since <= n_since;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_win <= n_win;
        end
    end

endmodule

FILE: hw/rtl/tss_count.sv
// tss_count: saturating line, match, character and word totals plus the in-word flag.
// Depends on tss_pkg.
module tss_count (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  tss_pkg::t_item       i_item,
    input  logic                 i_hit,
    output logic [tss_pkg::CNT_W-1:0] o_lines,
    output logic [tss_pkg::CNT_W-1:0] o_matches,
    output logic [tss_pkg::CNT_W-1:0] o_chars,
    output logic [tss_pkg::CNT_W-1:0] o_words
);
    import tss_pkg::*;

    logic [CNT_W-1:0] r_lines, r_matches, r_chars, r_words;
    logic [CNT_W-1:0] n_lines, n_matches, n_chars, n_words;
    logic             r_in_word, n_in_word;
    logic             sep, word_start;

    always_comb begin
        sep        = is_sep(i_item.text_byte);
        word_start = !sep && !r_in_word;
        n_lines    = sat_inc(r_lines, (i_item.text_byte == CH_NEWLINE) || i_item.is_last);
        n_matches  = sat_inc(r_matches, i_hit);
        n_chars    = sat_inc(r_chars, 1'b1);
        n_words    = sat_inc(r_words, word_start);
        n_in_word  = !sep && !i_item.is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines   <= '0;
            r_matches <= '0;
            r_chars   <= '0;
            r_words   <= '0;
            r_in_word <= 1'b0;
        end else if (i_adv) begin
            r_lines   <= n_lines;
            r_matches <= n_matches;
            r_chars   <= n_chars;
            r_words   <= n_words;
            r_in_word <= n_in_word;
        end
    end

    assign o_lines   = r_lines;
    assign o_matches = r_matches;
    assign o_chars   = r_chars;
    assign o_words   = r_words;

endmodule

FILE: hw/rtl/text_stream_statistics.sv
// text_stream_statistics: running line, word, character and search-word counts over a byte stream.
// Path: a request enters the input register, then its totals and valid flag enter the result register.
// One request per cycle unless output stalls; window compare and counter update are combinational.
// The input register takes a request while a result waits, so input stalls only when both are full.
// Reset (synchronous, active low) clears totals, window fill, valid flags; pattern length resets to 1.
// Depends on tss_pkg, tss_window, tss_count.
module text_stream_statistics #(
    parameter int MAX_PATTERN = tss_pkg::DEF_MAX_PATTERN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tss_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_is_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tss_pkg::CNT_W-1:0]     o_lines,
    output logic [tss_pkg::CNT_W-1:0]     o_matches_res,
    output logic [tss_pkg::CNT_W-1:0]     o_characters,
    output logic [tss_pkg::CNT_W-1:0]     o_words,
    output logic                          o_final_res
);
    import tss_pkg::*;

    logic [63:0] r_pat_low;
    logic [7:0]  r_pat_high;
    logic [3:0]  r_pat_len;
    logic        r_in_valid, r_out_valid, r_final;
    t_item       r_in;
    logic        adv, in_take, hit;

    assign adv        = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                CFG_PAT_HIGH: r_pat_high <= i_cfg_data[7:0];
                CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.text_byte <= i_text_byte;
            r_in.is_last   <= i_is_last;
        end
        if (adv) begin
            r_final <= r_in.is_last;
        end
    end

    tss_window #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_item     (r_in),
        .i_pat_low  (r_pat_low),
        .i_pat_high (r_pat_high),
        .i_pat_len  (r_pat_len),
        .o_hit      (hit)
    );

    tss_count u_count (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_item    (r_in),
        .i_hit     (hit),
        .o_lines   (o_lines),
        .o_matches (o_matches_res),
        .o_chars   (o_characters),
        .o_words   (o_words)
    );

    assign o_out_valid = r_out_valid;
    assign o_final_res = r_final;

endmodule

FILE: hw/rtl/tss_checker.sv
// tss_checker: port-level checks on the text stream statistics block, bound to the top level.
// Depends on tss_pkg and text_stream_statistics.
module tss_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [tss_pkg::CNT_W-1:0] o_lines,
    input logic [tss_pkg::CNT_W-1:0] o_matches_res,
    input logic [tss_pkg::CNT_W-1:0] o_characters,
    input logic [tss_pkg::CNT_W-1:0] o_words
);
    import tss_pkg::*;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_characters)
            && $stable(o_lines) && $stable(o_words) && $stable(o_matches_res)))
        else $error("stalled result changed");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_lines <= o_characters) && (o_words <= o_characters)
            && (o_matches_res <= o_characters)))
        else $error("a total exceeds the character count");

    a_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((o_characters >= $past(o_characters))
            && (o_lines >= $past(o_lines)) && (o_words >= $past(o_words))))
        else $error("a total decreased");

endmodule

bind text_stream_statistics tss_checker u_tss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_lines       (o_lines),
    .o_matches_res (o_matches_res),
    .o_characters  (o_characters),
    .o_words       (o_words)
);
